// ===== rtl/cdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Civil date unit package
// Shared codes, calendar constants, reciprocal multipliers and the month
// table used across the civil date / day number pipeline.
// ----------------------------------------------------------------------------
package cdd_pkg;

	localparam int NUM_STAGES = 12;

	localparam logic [1:0] CMD_TO_DAYS  = 2'd0;
	localparam logic [1:0] CMD_TO_DATE  = 2'd1;
	localparam logic [1:0] CMD_ADD_DAYS = 2'd2;
	localparam logic [1:0] CMD_DIFF     = 2'd3;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_DATE   = 2'd1;
	localparam logic [1:0] STATUS_YEAR_RANGE = 2'd2;

	localparam longint EPOCH_SHIFT  = 719468;
	localparam longint DAYS_PER_ERA = 146097;

	// Whole eras added to the year so that every year seen is positive.
	localparam longint YEAR_ERAS = 83;
	localparam longint YEAR_BIAS = YEAR_ERAS * 400;
	localparam longint DAYS_BIAS = EPOCH_SHIFT + YEAR_ERAS * DAYS_PER_ERA;

	// Whole eras added to the day count so that the era division sees
	// an unsigned dividend for every possible day number and offset.
	localparam longint ERA_BIAS = 14800;
	localparam longint Z_BIAS   = ERA_BIAS * DAYS_PER_ERA + EPOCH_SHIFT;

	localparam logic [17:0] ERA_DAYS     = 18'(DAYS_PER_ERA);
	localparam logic [17:0] ERA_LAST_DAY = 18'(DAYS_PER_ERA - 1);

	// Rounded-up reciprocals, exact for dividends below 2^16 (2^18 for the
	// last one). The era reciprocal is rounded down and followed by one
	// correction step.
	localparam logic [16:0] RECIP_25     = 17'(((64'd1 << 21) + 64'd24) / 64'd25);
	localparam logic [16:0] RECIP_365_16 = 17'(((64'd1 << 25) + 64'd364) / 64'd365);
	localparam logic [16:0] RECIP_9131   = 17'(((64'd1 << 30) + 64'd9130) / 64'd9131);
	localparam logic [18:0] RECIP_365_18 = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [28:0] RECIP_ERA    = 29'((64'd1 << 46) / 64'd146097);

	typedef struct packed {
		logic [1:0]         cmd;
		logic               bad;
		logic signed [31:0] days;
	} side_t;

	// First day of year for each month, counted from March.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/cdd_to_days.sv =====
// ----------------------------------------------------------------------------
// Date to day number
// Three pipeline stages: year bias and day of year, division of the year by
// one hundred, and the final sum of the leap-day terms.
// ----------------------------------------------------------------------------
module cdd_to_days (
	input  logic               clk,
	input  logic [2:0]         en,
	input  logic signed [15:0] year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	output logic signed [31:0] days,
	output logic               ok
);

	localparam longint YEAR_BIAS_C = cdd_pkg::YEAR_BIAS;

	logic        early;
	logic [3:0]  mp;
	logic [17:0] ysum;
	logic [8:0]  doy;
	logic        date_ok;

	logic [16:0] yp_s1;
	logic [8:0]  doy_s1;
	logic        ok_s1;

	logic [31:0] prod2;
	logic [16:0] yp_s2;
	logic [10:0] q100_s2;
	logic [8:0]  doy_s2;
	logic        ok_s2;

	logic [31:0] acc3;
	logic signed [31:0] days_s3;
	logic        ok_s3;

	// January and February count as months of the previous year.
	always_comb begin
		early   = (month <= 4'd2);
		mp      = early ? (month + 4'd9) : (month - 4'd3);
		ysum    = {{2{year[15]}}, year} - {17'd0, early} + 18'(YEAR_BIAS_C);
		doy     = cdd_pkg::month_start(mp) + {4'd0, day} - 9'd1;
		date_ok = (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			yp_s1  <= ysum[16:0];
			doy_s1 <= doy;
			ok_s1  <= date_ok;
		end
	end

	assign prod2 = 32'(yp_s1[16:2]) * 32'(cdd_pkg::RECIP_25);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			yp_s2   <= yp_s1;
			q100_s2 <= prod2[31:21];
			doy_s2  <= doy_s1;
			ok_s2   <= ok_s1;
		end
	end

	// 365*y + y/4 - y/100 + y/400 + day of year, less the bias.
	assign acc3 = 32'(yp_s2) * 32'd365 + 32'(yp_s2[16:2]) - 32'(q100_s2)
		+ 32'(q100_s2[10:2]) + 32'(doy_s2) - 32'(cdd_pkg::DAYS_BIAS);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			days_s3 <= signed'(acc3);
			ok_s3   <= ok_s2;
		end
	end

	assign days = days_s3;
	assign ok   = ok_s3;

endmodule

// ===== rtl/cdd_era_split.sv =====
// ----------------------------------------------------------------------------
// Era split
// Four pipeline stages: command decode and biased day count, reciprocal
// estimate of the era, remainder, and a single correction step.
// ----------------------------------------------------------------------------
module cdd_era_split (
	input  logic                clk,
	input  logic [3:0]          en,
	input  logic [1:0]          cmd,
	input  logic signed [31:0]  day_value,
	input  logic signed [31:0]  days_a,
	input  logic signed [31:0]  days_b,
	input  logic                ok_a,
	input  logic                ok_b,
	output logic [17:0]         doe,
	output logic signed [15:0]  era,
	output cdd_pkg::side_t      side
);

	logic signed [32:0] z;
	logic [32:0]        n;
	cdd_pkg::side_t     side4;

	logic [32:0]    n_s4;
	cdd_pkg::side_t side_s4;

	logic [47:0]    prod5;
	logic [32:0]    n_s5;
	logic [15:0]    qe_s5;
	cdd_pkg::side_t side_s5;

	logic [33:0]    prod6;
	logic [33:0]    rem6;
	logic [18:0]    r_s6;
	logic [15:0]    qe_s6;
	cdd_pkg::side_t side_s6;

	logic           wrap;
	logic [18:0]    r_fix;
	logic [15:0]    q_fix;
	logic [17:0]    doe_s7;
	logic signed [15:0] era_s7;
	cdd_pkg::side_t side_s7;

	always_comb begin
		z = (cmd == cdd_pkg::CMD_TO_DATE) ? 33'(day_value) : (33'(days_a) + 33'(day_value));
		// The bias keeps the dividend positive; the true value always fits.
		n = 33'(z) + 33'(cdd_pkg::Z_BIAS);
		side4.cmd = cmd;
		case (cmd) inside
			cdd_pkg::CMD_TO_DAYS, cdd_pkg::CMD_ADD_DAYS: side4.bad = !ok_a;
			cdd_pkg::CMD_DIFF:                           side4.bad = !(ok_a && ok_b);
			default:                                     side4.bad = 1'b0;
		endcase
		side4.days = (cmd == cdd_pkg::CMD_DIFF) ? (days_b - days_a) : days_a;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			n_s4    <= n;
			side_s4 <= side4;
		end
	end

	// The estimate is never above the true quotient and at most one below.
	assign prod5 = 48'(n_s4[32:14]) * 48'(cdd_pkg::RECIP_ERA);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_s5    <= n_s4;
			qe_s5   <= prod5[47:32];
			side_s5 <= side_s4;
		end
	end

	assign prod6 = 34'(qe_s5) * 34'(cdd_pkg::ERA_DAYS);
	assign rem6  = 34'(n_s5) - prod6;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			r_s6    <= rem6[18:0];
			qe_s6   <= qe_s5;
			side_s6 <= side_s5;
		end
	end

	always_comb begin
		wrap  = (r_s6 >= 19'(cdd_pkg::DAYS_PER_ERA));
		r_fix = wrap ? (r_s6 - 19'(cdd_pkg::DAYS_PER_ERA)) : r_s6;
		q_fix = qe_s6 + 16'(wrap);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			doe_s7  <= r_fix[17:0];
			era_s7  <= signed'(q_fix - 16'(cdd_pkg::ERA_BIAS));
			side_s7 <= side_s6;
		end
	end

	assign doe  = doe_s7;
	assign era  = era_s7;
	assign side = side_s7;

endmodule

// ===== rtl/cdd_to_date.sv =====
// ----------------------------------------------------------------------------
// Day of era to civil date
// Five pipeline stages: leap corrections, corrected day count, year of era,
// day of year, and month lookup with the result formatting. The last stage
// is the output register.
// ----------------------------------------------------------------------------
module cdd_to_date (
	input  logic                clk,
	input  logic [4:0]          en,
	input  logic [17:0]         doe,
	input  logic signed [15:0]  era,
	input  cdd_pkg::side_t      side,
	output logic signed [15:0]  out_year,
	output logic [3:0]          out_month,
	output logic [4:0]          out_day,
	output logic signed [31:0]  out_days,
	output logic [1:0]          status
);

	logic [32:0] pr1;
	logic [32:0] pr2;
	logic [6:0]  p1_s8;
	logic [2:0]  p2_s8;
	logic        last_s8;
	logic [17:0] doe_s8;
	logic signed [15:0] era_s8;
	cdd_pkg::side_t side_s8;

	logic [17:0] num;
	logic [17:0] num_s9;
	logic [17:0] doe_s9;
	logic signed [15:0] era_s9;
	cdd_pkg::side_t side_s9;

	logic [36:0] pr10;
	logic [8:0]  yoe_s10;
	logic [17:0] doe_s10;
	logic signed [15:0] era_s10;
	cdd_pkg::side_t side_s10;

	logic [1:0]  c100;
	logic [17:0] ydays;
	logic [17:0] doy_full;
	logic [8:0]  doy_s11;
	logic [8:0]  yoe_s11;
	logic signed [15:0] era_s11;
	cdd_pkg::side_t side_s11;

	logic [3:0]  mp;
	logic        jan_feb;
	logic [3:0]  month;
	logic [8:0]  dom;
	logic [4:0]  dnum;
	logic signed [31:0] yr;
	logic        range_bad;

	logic signed [15:0] year_d;
	logic [3:0]  month_d;
	logic [4:0]  day_d;
	logic signed [31:0] days_d;
	logic [1:0]  status_d;

	logic signed [15:0] year_s12;
	logic [3:0]  month_s12;
	logic [4:0]  day_s12;
	logic signed [31:0] days_s12;
	logic [1:0]  status_s12;

	// doe/1460 and doe/36524 as (doe/4)/365 and (doe/4)/9131.
	assign pr1 = 33'(doe[17:2]) * 33'(cdd_pkg::RECIP_365_16);
	assign pr2 = 33'(doe[17:2]) * 33'(cdd_pkg::RECIP_9131);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p1_s8   <= pr1[31:25];
			p2_s8   <= pr2[32:30];
			last_s8 <= (doe == cdd_pkg::ERA_LAST_DAY);
			doe_s8  <= doe;
			era_s8  <= era;
			side_s8 <= side;
		end
	end

	assign num = doe_s8 - 18'(p1_s8) + 18'(p2_s8) - 18'(last_s8);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s9  <= num;
			doe_s9  <= doe_s8;
			era_s9  <= era_s8;
			side_s9 <= side_s8;
		end
	end

	assign pr10 = 37'(num_s9) * 37'(cdd_pkg::RECIP_365_18);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			yoe_s10  <= pr10[35:27];
			doe_s10  <= doe_s9;
			era_s10  <= era_s9;
			side_s10 <= side_s9;
		end
	end

	// The year of era is below 400, so its hundreds come from compares.
	always_comb begin
		if (yoe_s10 >= 9'd300) begin
			c100 = 2'd3;
		end else if (yoe_s10 >= 9'd200) begin
			c100 = 2'd2;
		end else if (yoe_s10 >= 9'd100) begin
			c100 = 2'd1;
		end else begin
			c100 = 2'd0;
		end
		ydays    = 18'(yoe_s10) * 18'd365 + 18'(yoe_s10[8:2]) - 18'(c100);
		doy_full = doe_s10 - ydays;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			doy_s11  <= doy_full[8:0];
			yoe_s11  <= yoe_s10;
			era_s11  <= era_s10;
			side_s11 <= side_s10;
		end
	end

	always_comb begin
		mp = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s11 >= cdd_pkg::month_start(4'(k))) begin
				mp = 4'(k);
			end
		end
		jan_feb   = (mp >= 4'd10);
		month     = jan_feb ? (mp - 4'd9) : (mp + 4'd3);
		dom       = doy_s11 - cdd_pkg::month_start(mp);
		dnum      = dom[4:0] + 5'd1;
		yr        = 32'(era_s11) * 32'sd400 + $signed({23'd0, yoe_s11})
			+ $signed({31'd0, jan_feb});
		range_bad = (yr < -32'sd32768) || (yr > 32'sd32767);
	end

	always_comb begin
		year_d   = '0;
		month_d  = '0;
		day_d    = '0;
		days_d   = '0;
		status_d = cdd_pkg::STATUS_OK;
		case (side_s11.cmd) inside
			cdd_pkg::CMD_TO_DAYS, cdd_pkg::CMD_DIFF: begin
				if (side_s11.bad) begin
					status_d = cdd_pkg::STATUS_BAD_DATE;
				end else begin
					days_d = side_s11.days;
				end
			end
			default: begin
				if (side_s11.bad) begin
					status_d = cdd_pkg::STATUS_BAD_DATE;
				end else if (range_bad) begin
					status_d = cdd_pkg::STATUS_YEAR_RANGE;
				end else begin
					year_d  = yr[15:0];
					month_d = month;
					day_d   = dnum;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			year_s12   <= year_d;
			month_s12  <= month_d;
			day_s12    <= day_d;
			days_s12   <= days_d;
			status_s12 <= status_d;
		end
	end

	assign out_year  = year_s12;
	assign out_month = month_s12;
	assign out_day   = day_s12;
	assign out_days  = days_s12;
	assign status    = status_s12;

endmodule

// ===== rtl/civil_date_day_number_unit_top.sv =====
// Each item passes 12 register stages on its way to the output.
// Throughput: one item per cycle while results are taken; the pipeline of
// reciprocal multipliers and adders sets it, each stage holding one item.
// Each stage stalls only while it and every stage after it hold an item
// and the result is not taken, so bubbles are squeezed out.
// Reset clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
// Civil date / day number unit
// Converts between proleptic Gregorian dates and day numbers counted from
// 1970-01-01, adds day offsets to dates and counts days between dates.
// ----------------------------------------------------------------------------
module civil_date_day_number_unit_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] year_a,
	input  logic [3:0]         month_a,
	input  logic [4:0]         day_a,
	input  logic signed [15:0] year_b,
	input  logic [3:0]         month_b,
	input  logic [4:0]         day_b,
	input  logic signed [31:0] day_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_year,
	output logic [3:0]         out_month,
	output logic [4:0]         out_day,
	output logic signed [31:0] out_days,
	output logic [1:0]         status
);

	localparam int NS = cdd_pkg::NUM_STAGES;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] vld_in;
	logic [NS-1:0] en;

	logic [1:0]         cmd_s1, cmd_s2, cmd_s3;
	logic signed [31:0] val_s1, val_s2, val_s3;

	logic signed [31:0] days_a;
	logic signed [31:0] days_b;
	logic               ok_a;
	logic               ok_b;

	logic [17:0]        doe;
	logic signed [15:0] era;
	cdd_pkg::side_t     side;

	// A stage may load when there is a hole at or after it, or the output moves.
	for (genvar g = 0; g < NS; g++) begin : g_en
		assign en[g] = out_ready || !(&vld_q[NS-1:g]);
	end

	assign vld_in = {vld_q[NS-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NS-1];

	// Command and offset ride alongside the date conversion stages.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			cmd_s1 <= cmd;
			val_s1 <= day_value;
		end
		if (en[1]) begin
			cmd_s2 <= cmd_s1;
			val_s2 <= val_s1;
		end
		if (en[2]) begin
			cmd_s3 <= cmd_s2;
			val_s3 <= val_s2;
		end
	end

	cdd_to_days u_days_a (
		.clk   (clk),
		.en    (en[2:0]),
		.year  (year_a),
		.month (month_a),
		.day   (day_a),
		.days  (days_a),
		.ok    (ok_a)
	);

	cdd_to_days u_days_b (
		.clk   (clk),
		.en    (en[2:0]),
		.year  (year_b),
		.month (month_b),
		.day   (day_b),
		.days  (days_b),
		.ok    (ok_b)
	);

	cdd_era_split u_era (
		.clk       (clk),
		.en        (en[6:3]),
		.cmd       (cmd_s3),
		.day_value (val_s3),
		.days_a    (days_a),
		.days_b    (days_b),
		.ok_a      (ok_a),
		.ok_b      (ok_b),
		.doe       (doe),
		.era       (era),
		.side      (side)
	);

	cdd_to_date u_date (
		.clk       (clk),
		.en        (en[11:7]),
		.doe       (doe),
		.era       (era),
		.side      (side),
		.out_year  (out_year),
		.out_month (out_month),
		.out_day   (out_day),
		.out_days  (out_days),
		.status    (status)
	);

endmodule

// ===== rtl/cdd_checker.sv =====
// ----------------------------------------------------------------------------
// Civil date unit port checker
// Watches the top level ports for stall behavior and result consistency.
// ----------------------------------------------------------------------------
module cdd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] out_year,
	input logic [3:0]         out_month,
	input logic [4:0]         out_day,
	input logic signed [31:0] out_days,
	input logic [1:0]         status
);

	// The input side only stalls when the pipeline is full and backed up.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while the output was free");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid
			&& $stable({out_year, out_month, out_day, out_days, status})))
		else $error("stalled result item changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == cdd_pkg::STATUS_OK || status == cdd_pkg::STATUS_BAD_DATE
			|| status == cdd_pkg::STATUS_YEAR_RANGE))
		else $error("undefined status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != cdd_pkg::STATUS_OK) |->
			(out_year == 16'sd0 && out_month == 4'd0 && out_day == 5'd0 && out_days == 32'sd0))
		else $error("error result carries data");

	a_date_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == cdd_pkg::STATUS_OK && out_month != 4'd0) |->
			(out_month <= 4'd12 && out_day != 5'd0 && out_days == 32'sd0))
		else $error("malformed result date");

endmodule

bind civil_date_day_number_unit_top cdd_checker u_cdd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_year  (out_year),
	.out_month (out_month),
	.out_day   (out_day),
	.out_days  (out_days),
	.status    (status)
);
